>>> hdl/jvks_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// jvks_pkg - shared types and constants for the schema version key scanner
// Request/response payloads, the classified byte passed from front to back,
// status codes, scanner phases and the quoted key text.
// ============================================================================
package jvks_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int KEY_LAST        = 14;        // index of the closing quote
   localparam logic [23:0] VALUE_LIMIT = 24'd1000000;
   localparam logic [3:0]  MAX_DIGITS  = 4'd10;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_KEY   = 2'd1,
      ST_SYNTAX   = 2'd2,
      ST_FRACTION = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      PH_SEARCH     = 6'b000001,
      PH_PRE_COLON  = 6'b000010,
      PH_POST_COLON = 6'b000100,
      PH_DIGITS     = 6'b001000,
      PH_TEN_DIGITS = 6'b010000,
      PH_DECIDED    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] version;
   } rsp_type;

   // byte after classification in the front end
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
      logic       is_zero;
      logic       is_space;
      logic       is_digit;
      logic       is_quote;
      logic       is_colon;
      logic       is_frac;     // '.', 'e' or 'E'
      logic       is_opener;   // '{' or ','
   } cls_type;

   // queue occupancy seen by its neighbors
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // quoted key text, index 0 is the opening quote
   function automatic logic [7:0] key_byte(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h22;  // "
         4'd1:    ch = 8'h73;  // s
         4'd2:    ch = 8'h63;  // c
         4'd3:    ch = 8'h68;  // h
         4'd4:    ch = 8'h65;  // e
         4'd5:    ch = 8'h6D;  // m
         4'd6:    ch = 8'h61;  // a
         4'd7:    ch = 8'h56;  // V
         4'd8:    ch = 8'h65;  // e
         4'd9:    ch = 8'h72;  // r
         4'd10:   ch = 8'h73;  // s
         4'd11:   ch = 8'h69;  // i
         4'd12:   ch = 8'h6F;  // o
         4'd13:   ch = 8'h6E;  // n
         4'd14:   ch = 8'h22;  // "
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> hdl/jvks_front.sv
`timescale 1ns / 1ps
// ============================================================================
// jvks_front - request intake and byte classification
// Takes one request per cycle, while req_full is low, into a register with
// character class flags, and hands it on to the queue when the queue has room.
// ============================================================================
module jvks_front import jvks_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_item,
   input  q_stat_type q_stat,
   output logic       q_push,
   output cls_type    q_item
);

   logic    valid_ff, valid_in;
   cls_type item_ff, item_in;
   logic    accept;
   logic [7:0] b;

   assign req_full = valid_ff && q_stat.full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff && !q_stat.full;
   assign q_item   = item_ff;
   assign b        = req_item.text_byte;

   always_comb begin
      item_in.text_byte = b;
      item_in.last_byte = req_item.last_byte;
      item_in.is_zero   = (b == 8'h00);
      item_in.is_space  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
      item_in.is_digit  = (b >= 8'h30) && (b <= 8'h39);
      item_in.is_quote  = (b == CH_QUOTE);
      item_in.is_colon  = (b == CH_COLON);
      item_in.is_frac   = (b == CH_DOT) || (b == CH_LOW_E) || (b == CH_UP_E);
      item_in.is_opener = (b == CH_LBRACE) || (b == CH_COMMA);
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> hdl/jvks_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// jvks_queue - short queue of classified bytes
// Decouples the intake from the scanner so either side can stall alone.
// ============================================================================
module jvks_queue import jvks_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cls_type    push_item,
   input  logic       pop,
   output cls_type    head_item,
   output q_stat_type stat
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   cls_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   assign stat.full  = (count_ff == CNT_FULL);
   assign stat.empty = (count_ff == '0);
   assign do_wr      = push && !stat.full;
   assign do_rd      = pop && !stat.empty;
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hdl/jvks_back.sv
`timescale 1ns / 1ps
// ============================================================================
// jvks_back - key scanner and response register
// Runs the key match / colon / digit state machine on one classified byte per cycle
// (a last byte waits for a free response register) and holds the response until it is popped.
// ============================================================================
module jvks_back import jvks_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cls_type    head_item,
   input  q_stat_type q_stat,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_item
);

   phase_type   phase_ff, phase_in, ph;
   logic [3:0]  match_ff, match_in;
   logic        sig_open_ff, sig_open_in;   // last significant byte was '{' or ','
   logic        cand_ff, cand_in;
   logic [23:0] value_ff, value_in;
   logic [3:0]  digits_ff, digits_in;
   status_type  decided_ff, decided_in, st;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   cls_type     c;
   logic        out_room;
   logic [23:0] value_x10;
   logic [3:0]  digits_inc;

   assign c          = head_item;
   assign out_room   = !rsp_valid_ff || rsp_pop;
   assign q_pop      = !q_stat.empty && (!c.last_byte || out_room);
   assign rsp_empty  = !rsp_valid_ff;
   assign rsp_item   = rsp_ff;
   assign value_x10  = {value_ff[20:0], 3'b000} + {value_ff[22:0], 1'b0};
   assign digits_inc = digits_ff + 1'b1;

   // scanner update for one byte
   always_comb begin
      phase_in    = phase_ff;
      match_in    = match_ff;
      sig_open_in = sig_open_ff;
      cand_in     = cand_ff;
      value_in    = value_ff;
      digits_in   = digits_ff;
      decided_in  = decided_ff;
      if (phase_ff != PH_DECIDED) begin
         if (c.is_zero) begin
            // end of text inside the stream
            phase_in = PH_DECIDED;
            unique case (phase_ff) inside
               PH_SEARCH:                     decided_in = ST_NO_KEY;
               PH_PRE_COLON, PH_POST_COLON:   decided_in = ST_SYNTAX;
               PH_DIGITS, PH_TEN_DIGITS:      decided_in = ST_OK;
               default:                       decided_in = decided_ff;
            endcase
         end else begin
            unique case (phase_ff) inside
               PH_SEARCH: begin
                  if (c.is_quote && match_ff == 4'(KEY_LAST) && cand_ff) begin
                     phase_in = PH_PRE_COLON;
                     match_in = '0;
                  end else begin
                     if (c.is_quote) begin
                        cand_in  = sig_open_ff;
                        match_in = 4'd1;
                     end else if (match_ff >= 4'd1 && match_ff < 4'(KEY_LAST) &&
                                  c.text_byte == key_byte(match_ff)) begin
                        match_in = match_ff + 1'b1;
                     end else begin
                        match_in = '0;
                     end
                     if (!c.is_space) begin
                        sig_open_in = c.is_opener;
                     end
                  end
               end
               PH_PRE_COLON: begin
                  if (c.is_colon) begin
                     phase_in = PH_POST_COLON;
                  end else if (!c.is_space) begin
                     phase_in   = PH_DECIDED;
                     decided_in = ST_SYNTAX;
                  end
               end
               PH_POST_COLON, PH_DIGITS: begin
                  if (c.is_digit) begin
                     if (value_ff < VALUE_LIMIT) begin
                        value_in = value_x10 + {20'd0, c.text_byte[3:0]};
                     end
                     digits_in = digits_inc;
                     phase_in  = (digits_inc >= MAX_DIGITS) ? PH_TEN_DIGITS : PH_DIGITS;
                  end else if (phase_ff == PH_POST_COLON) begin
                     if (!c.is_space) begin
                        phase_in   = PH_DECIDED;
                        decided_in = ST_SYNTAX;
                     end
                  end else begin
                     phase_in   = PH_DECIDED;
                     decided_in = c.is_frac ? ST_FRACTION : ST_OK;
                  end
               end
               PH_TEN_DIGITS: begin
                  phase_in   = PH_DECIDED;
                  decided_in = c.is_frac ? ST_FRACTION : ST_OK;
               end
               default: begin
                  phase_in   = PH_DECIDED;
                  decided_in = ST_NO_KEY;
               end
            endcase
         end
      end
   end

   // outcome when the text ends after this byte
   always_comb begin
      ph = phase_in;
      unique case (ph) inside
         PH_SEARCH:                   st = ST_NO_KEY;
         PH_PRE_COLON, PH_POST_COLON: st = ST_SYNTAX;
         PH_DIGITS, PH_TEN_DIGITS:    st = ST_OK;
         default:                     st = decided_in;
      endcase
      rsp_in.status  = st;
      rsp_in.version = (st == ST_OK) ? value_in : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      if (q_pop && c.last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         match_ff     <= '0;
         sig_open_ff  <= 1'b0;
         cand_ff      <= 1'b0;
         value_ff     <= '0;
         digits_ff    <= '0;
         decided_ff   <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            if (c.last_byte) begin
               phase_ff    <= PH_SEARCH;
               match_ff    <= '0;
               sig_open_ff <= 1'b0;
               cand_ff     <= 1'b0;
               value_ff    <= '0;
               digits_ff   <= '0;
               decided_ff  <= ST_OK;
            end else begin
               phase_ff    <= phase_in;
               match_ff    <= match_in;
               sig_open_ff <= sig_open_in;
               cand_ff     <= cand_in;
               value_ff    <= value_in;
               digits_ff   <= digits_in;
               decided_ff  <= decided_in;
            end
         end
      end
      if (q_pop && c.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> hdl/json_version_key_scanner.sv
`timescale 1ns / 1ps
// ============================================================================
// json_version_key_scanner - streaming reader of a document's schema version
// Scans document bytes for the first qualifying "schemaVersion" key and
// reports its integer value, or why it was refused, at the last byte.
// ============================================================================
// Push one document byte per request (req_item.text_byte) and mark the final
// byte with req_item.last_byte. The block takes a request every cycle while
// full is low, so a document streams at one byte per clock. The key counts
// only if the nearest non-whitespace byte before its opening quote is '{' or
// ','; it must be followed by optional whitespace, ':', optional whitespace
// and a digit. Up to ten digits are read and the value stops growing once it
// reaches 1000000; a '.', 'e' or 'E' right after the digits refuses the
// document. A zero byte ends the text early: the outcome is fixed there and
// later bytes up to the last one are ignored. Exactly one response comes per
// last byte: status 0 accepted (version holds the value), 1 no key, 2 missing
// colon or digit, 3 fraction or exponent (version is 0 unless accepted). All
// scan state clears after each last byte, so documents may follow back to
// back. Throughput is one byte per cycle while no last byte waits for room,
// set by the scanner update in the back end. A last byte passes the intake
// register and then the queue before the scanner loads the response register.
// While a response waits unpopped, bytes keep flowing into the
// intake and queue; full rises only when the queue of QUEUE_DEPTH entries and
// the intake register are all occupied behind a waiting last byte.
// ============================================================================
module json_version_key_scanner import jvks_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   // request side
   input  logic    push,
   output logic    full,
   input  req_type req_item,
   // response side
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_item
);

   q_stat_type q_stat;
   logic       q_push;
   logic       q_pop;
   cls_type    q_in_item;
   cls_type    q_head_item;

   // intake and classification
   jvks_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (push),
      .req_full  (full),
      .req_item  (req_item),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_item    (q_in_item)
   );

   // decoupling queue between intake and scanner
   jvks_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .pop       (q_pop),
      .head_item (q_head_item),
      .stat      (q_stat)
   );

   // scanner and response register
   jvks_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (q_head_item),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_item  (rsp_item)
   );

endmodule
